@@ rtl/mwc_pkg.sv @@
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared types and constants for the largest cycle sum block: transaction
// payloads, node colour codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mwc_pkg;

    // default graph capacity
    localparam int MAX_NODES_DEF = 1024;

    // fixed field widths of the transactions
    localparam int SUCC_W    = 10;
    localparam int SUM_OUT_W = 20;

    // input transaction: one node of the graph
    typedef struct packed {
        logic [SUCC_W-1:0] successor;
        logic              has_successor;
        logic              last_node;
    } in_item_t;

    // result transaction: one per graph
    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] best_cycle_sum;
        logic                        cycle_found;
    } out_item_t;

    // node colour held in the node state memory
    typedef enum logic [1:0] {
        COL_UNVISITED = 2'd0,
        COL_ACTIVE    = 2'd1,
        COL_DONE      = 2'd2
    } colour_t;

endpackage

`default_nettype wire

@@ rtl/mwc_ram.sv @@
// ----------------------------------------------------------------------------
// mwc_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/mwc_walk.sv @@
// ----------------------------------------------------------------------------
// mwc_walk
// Graph store and walk sequencer. Loads successors, then scans every node,
// walks successor chains from unvisited nodes, scores cycles and marks the
// walked chain done. Node colour and running sum share one memory.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_walk
    import mwc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load_valid,
    input  wire in_item_t  load_item,
    output logic           load_ready,
    input  wire logic      out_free,
    output logic           res_valid,
    output out_item_t      res
);

    localparam int    NW     = $clog2(MAX_NODES);
    localparam int    CW     = $clog2(MAX_NODES + 1);
    localparam int    CMPW   = (CW > SUCC_W) ? CW : SUCC_W;
    localparam longint MaxSum = (longint'(MAX_NODES) * longint'(MAX_NODES - 1)) / 2;
    localparam int    SUMB   = $clog2(MaxSum + 1);
    localparam int    SW     = (SUMB > SUM_OUT_W) ? SUMB : SUM_OUT_W;
    localparam int    STW    = 2 + SW;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WALK_SUCC,
        ST_WALK_COL,
        ST_FIN_FIRST,
        ST_FIN_STEP,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   lc_reg, lc_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [NW-1:0]   nxt_reg, nxt_next;
    logic [NW-1:0]   last_reg, last_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [SW-1:0]   best_reg, best_next;
    logic            any_reg, any_next;
    logic            res_valid_reg, res_valid_next;
    out_item_t       res_reg, res_next;

    // memory ports
    logic              succ_we;
    logic [NW-1:0]     succ_waddr;
    logic [SUCC_W:0]   succ_wdata;
    logic [NW-1:0]     succ_raddr;
    logic [SUCC_W:0]   succ_rdata;
    logic              st_we;
    logic [NW-1:0]     st_waddr;
    logic [STW-1:0]    st_wdata;
    logic [NW-1:0]     st_raddr;
    logic [STW-1:0]    st_rdata;

    // decoded read data
    colour_t           st_col;
    logic [SW-1:0]     st_sum;
    logic [SUCC_W-1:0] succ_idx;
    logic [NW-1:0]     succ_node;
    logic              succ_ok;
    logic [SW-1:0]     cand;
    logic [CW-1:0]     lc_inc;

    // successor store: {has successor, index}
    mwc_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (SUCC_W + 1)
    ) u_succ_ram (
        .aclk  (aclk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (succ_wdata),
        .raddr (succ_raddr),
        .rdata (succ_rdata)
    );

    // node state store: {colour, running sum}
    mwc_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (STW)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign st_col    = colour_t'(st_rdata[STW-1 -: 2]);
    assign st_sum    = st_rdata[SW-1:0];
    assign succ_idx  = succ_rdata[SUCC_W-1:0];
    assign succ_node = NW'(succ_idx);
    // an index at or past the node count counts as no edge
    assign succ_ok   = succ_rdata[SUCC_W] && (CMPW'(succ_idx) < CMPW'(count_reg));
    // cycle sum: path sum at the tail minus path sum before the loop entry
    assign cand      = sum_reg - st_sum + SW'(nxt_reg);
    assign lc_inc    = lc_reg + CW'(1);

    assign load_ready = (state_reg == ST_LOAD);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // sequencer next state and memory control
    always_comb begin
        state_next     = state_reg;
        lc_next        = lc_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        any_next       = any_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        succ_we        = 1'b0;
        succ_waddr     = '0;
        succ_wdata     = '0;
        succ_raddr     = '0;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        st_raddr       = '0;

        unique case (state_reg)
            ST_LOAD: begin
                if (load_valid) begin
                    // store node and clear its colour; surplus nodes are dropped
                    if (lc_reg < CW'(MAX_NODES)) begin
                        succ_we    = 1'b1;
                        succ_waddr = lc_reg[NW-1:0];
                        succ_wdata = {load_item.has_successor, load_item.successor};
                        st_we      = 1'b1;
                        st_waddr   = lc_reg[NW-1:0];
                        st_wdata   = {COL_UNVISITED, {SW{1'b0}}};
                        lc_next    = lc_inc;
                    end
                    if (load_item.last_node) begin
                        count_next = (lc_reg < CW'(MAX_NODES)) ? lc_inc : lc_reg;
                        lc_next    = '0;
                        i_next     = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD: begin
                if (i_reg == count_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    st_raddr   = i_reg[NW-1:0];
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK: begin
                if (st_col == COL_UNVISITED) begin
                    // start a walk here
                    st_we      = 1'b1;
                    st_waddr   = i_reg[NW-1:0];
                    st_wdata   = {COL_ACTIVE, SW'(i_reg)};
                    succ_raddr = i_reg[NW-1:0];
                    cur_next   = i_reg[NW-1:0];
                    sum_next   = SW'(i_reg);
                    state_next = ST_WALK_SUCC;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_WALK_SUCC: begin
                if (succ_ok) begin
                    nxt_next   = succ_node;
                    st_raddr   = succ_node;
                    state_next = ST_WALK_COL;
                end else begin
                    last_next  = cur_reg;
                    state_next = ST_FIN_FIRST;
                end
            end

            ST_WALK_COL: begin
                case (st_col)
                    COL_UNVISITED: begin
                        sum_next   = sum_reg + SW'(nxt_reg);
                        st_we      = 1'b1;
                        st_waddr   = nxt_reg;
                        st_wdata   = {COL_ACTIVE, sum_reg + SW'(nxt_reg)};
                        succ_raddr = nxt_reg;
                        cur_next   = nxt_reg;
                        state_next = ST_WALK_SUCC;
                    end
                    COL_ACTIVE: begin
                        // back onto the current path: a cycle
                        any_next = 1'b1;
                        if (!any_reg || (cand > best_reg)) begin
                            best_next = cand;
                        end
                        last_next  = cur_reg;
                        state_next = ST_FIN_FIRST;
                    end
                    default: begin
                        last_next  = cur_reg;
                        state_next = ST_FIN_FIRST;
                    end
                endcase
            end

            ST_FIN_FIRST: begin
                // mark walk start done, fetch its successor
                st_we      = 1'b1;
                st_waddr   = i_reg[NW-1:0];
                st_wdata   = {COL_DONE, {SW{1'b0}}};
                succ_raddr = i_reg[NW-1:0];
                if (i_reg[NW-1:0] == last_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end else begin
                    state_next = ST_FIN_STEP;
                end
            end

            ST_FIN_STEP: begin
                // follow the chain one node per cycle up to the walk tail
                st_we      = 1'b1;
                st_waddr   = succ_node;
                st_wdata   = {COL_DONE, {SW{1'b0}}};
                succ_raddr = succ_node;
                if (succ_node == last_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    res_valid_next          = 1'b1;
                    res_next.cycle_found    = any_reg;
                    res_next.best_cycle_sum = any_reg ? best_reg[SUM_OUT_W-1:0]
                                                      : {SUM_OUT_W{1'b1}};
                    best_next               = '0;
                    any_next                = 1'b0;
                    state_next              = ST_LOAD;
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            lc_reg        <= '0;
            any_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lc_reg        <= lc_next;
            any_reg       <= any_next;
            res_valid_reg <= res_valid_next;
        end
        count_reg <= count_next;
        i_reg     <= i_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        last_reg  <= last_next;
        sum_reg   <= sum_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/max_weight_cycle_functional_graph.sv @@
// ----------------------------------------------------------------------------
// max_weight_cycle_functional_graph
// Largest sum of node indices over the cycles of a functional graph.
//
// Input channel (s_): one transaction per node, in node order from node 0,
// carrying its successor and whether it has one. A transaction with
// last_node set closes the graph, and node transactions are taken whenever
// the block is loading. Nodes beyond MAX_NODES are dropped; their last flag
// still closes the graph. After the closing transaction the input stalls
// while the graph is processed: the scan reads the state of every node, a
// walk follows the successor chain from each unvisited node and the walked
// chain is then marked done. Every node is walked once. After the scan the
// result passes the emit state and the res_valid register to m_valid.
// Result channel (m_): one transaction per graph with the largest cycle sum
// (-1 if none) and a cycle flag. The result sits in an output register, so
// loading of the next graph goes on while it waits; if it is still untaken
// when the next graph finishes, processing holds until the receiver takes it.
// Reset (aresetn, synchronous, active low) empties the graph and the output.
// No clearing pass is needed: loading a node resets its colour.
// ----------------------------------------------------------------------------
`default_nettype none

module max_weight_cycle_functional_graph
    import mwc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      load_ready;
    logic      out_free;
    logic      res_valid;
    out_item_t res;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    mwc_walk #(
        .MAX_NODES (MAX_NODES)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (s_valid && load_ready),
        .load_item  (s_data),
        .load_ready (load_ready),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign s_ready  = load_ready;
    // slot is free when empty or being emptied this cycle
    assign out_free = !m_valid_reg || m_ready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
